/* sv/pps_pkg.sv */
// Shared constants and types of the preemptive priority scheduler.
`default_nettype none
package pps_pkg;

    localparam int MAX_PROCS = 16;
    localparam int SLOT_W    = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
    localparam int COUNT_W   = $clog2(MAX_PROCS + 1);

    localparam int ID_W    = 8;
    localparam int TIME_W  = 16;
    localparam int NICE_W  = 6;
    localparam int BURST_W = 16;
    localparam int SIM_W   = 32;

    typedef enum logic [1:0] {
        CMD_LOAD  = 2'd0,
        CMD_TICK  = 2'd1,
        CMD_CLEAR = 2'd2
    } t_cmd;

    typedef struct packed {
        logic capture;
        logic exec;
        logic scan_step;
        logic update;
        logic out_load;
    } t_ctrl;

    typedef struct packed {
        logic is_tick;
        logic empty;
        logic scan_last;
        logic out_free;
    } t_stat;

    typedef struct packed {
        logic              load_error;
        logic              all_done;
        logic              finished;
        logic              first_run;
        logic              switched;
        logic [ID_W-1:0]   running_id;
        logic              busy_res;
        logic [SIM_W-1:0]  slot_time;
    } t_result;

endpackage
`default_nettype wire

/* sv/preemptive_priority_scheduler_top.sv */
// Top level of the preemptive priority scheduler: stream ports, controller and datapath.
//
// Commands arrive on the s_axis channel, with the command code in s_axis_tuser
// (0 load a process, 1 tick one time unit, 2 clear the table and time). Every
// command yields exactly one result transaction on the m_axis channel.
// A load or a clear passes through the execute and result states. A tick also
// scans the loaded entries of the table one per cycle through a single priority
// comparator, then advances simulated time in an update state; it skips the scan
// when the table is empty. The result is offered in the same cycle that the block
// is free again. One command is worked on at a time; s_axis_tready is high
// whenever the block is waiting for a command.
// The result sits in an output register: a new command is accepted while the
// previous result still waits, and the block then holds its next result until
// the receiver takes the pending one, so a stalled receiver never loses data.
// Synchronous reset empties the table, clears simulated time and the counters,
// and drops any pending result.
`default_nettype none
module preemptive_priority_scheduler_top
    import pps_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // proc_id[7:0], arrival_time[23:8], nice_value[29:24], burst_length[45:30], zero[47:46]
    input  wire logic [47:0] s_axis_tdata,
    // cmd[1:0]
    input  wire logic [1:0]  s_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // slot_time[31:0], busy_res[32], running_id[40:33], switched[41], first_run[42],
    // finished[43], all_done[44], load_error[45], zero[47:46]
    output logic [47:0]      m_axis_tdata
);

    t_ctrl   ctrl;
    t_stat   stat;
    t_result result;

    pps_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (stat),
        .o_ctrl     (ctrl)
    );

    pps_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (ctrl),
        .o_stat      (stat),
        .i_cmd       (s_axis_tuser),
        .i_proc_id   (s_axis_tdata[7:0]),
        .i_arrival   (s_axis_tdata[23:8]),
        .i_nice      (s_axis_tdata[29:24]),
        .i_burst     (s_axis_tdata[45:30]),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_result    (result)
    );

    assign m_axis_tdata = {2'b00, result.load_error, result.all_done, result.finished,
                           result.first_run, result.switched, result.running_id,
                           result.busy_res, result.slot_time};

endmodule
`default_nettype wire

/* sv/pps_ctrl.sv */
// Sequencing state machine of the preemptive priority scheduler.
`default_nettype none
module pps_ctrl
    import pps_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_in_valid,
    output logic       o_in_ready,
    input  t_stat      i_stat,
    output t_ctrl      o_ctrl
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_UPDATE,
        S_RESULT
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_ctrl  = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_ctrl.capture = 1'b1;
                    n_state        = S_EXEC;
                end
            end
            S_EXEC: begin
                o_ctrl.exec = 1'b1;
                if (!i_stat.is_tick) begin
                    n_state = S_RESULT;
                end else if (i_stat.empty) begin
                    n_state = S_UPDATE;
                end else begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                o_ctrl.scan_step = 1'b1;
                if (i_stat.scan_last) begin
                    n_state = S_UPDATE;
                end
            end
            S_UPDATE: begin
                o_ctrl.update = 1'b1;
                n_state       = S_RESULT;
            end
            S_RESULT: begin
                if (i_stat.out_free) begin
                    o_ctrl.out_load = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule
`default_nettype wire

/* sv/pps_datapath.sv */
// Process table, selection comparator, counters and output register of the scheduler.
`default_nettype none
module pps_datapath
    import pps_pkg::*;
(
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  t_ctrl                          i_ctrl,
    output t_stat                          o_stat,
    input  wire logic [1:0]                i_cmd,
    input  wire logic [ID_W-1:0]           i_proc_id,
    input  wire logic [TIME_W-1:0]         i_arrival,
    input  wire logic signed [NICE_W-1:0]  i_nice,
    input  wire logic [BURST_W-1:0]        i_burst,
    output logic                           o_out_valid,
    input  wire logic                      i_out_ready,
    output t_result                        o_result
);

    logic [1:0]                r_cmd;
    logic [ID_W-1:0]           r_id_in;
    logic [TIME_W-1:0]         r_arr_in;
    logic signed [NICE_W-1:0]  r_nice_in;
    logic [BURST_W-1:0]        r_burst_in;

    logic [ID_W-1:0]           r_ent_id    [MAX_PROCS];
    logic [TIME_W-1:0]         r_ent_arr   [MAX_PROCS];
    logic signed [NICE_W-1:0]  r_ent_nice  [MAX_PROCS];
    logic [BURST_W-1:0]        r_ent_rem   [MAX_PROCS];
    logic [MAX_PROCS-1:0]      r_ent_done;
    logic [MAX_PROCS-1:0]      r_ent_started;

    logic [SIM_W-1:0]          r_sim_time;
    logic [COUNT_W-1:0]        r_load_count;
    logic [COUNT_W-1:0]        r_done_count;
    logic                      r_last_valid;
    logic [SLOT_W-1:0]         r_last_slot;

    logic [SLOT_W-1:0]         r_scan_idx;
    logic                      r_best_found;
    logic [SLOT_W-1:0]         r_best_slot;
    logic signed [NICE_W-1:0]  r_best_nice;
    logic [TIME_W-1:0]         r_best_arr;
    logic [ID_W-1:0]           r_best_id;
    logic [BURST_W-1:0]        r_best_rem;

    t_result                   r_res;
    t_result                   r_out;
    logic                      r_out_valid;

    t_result                   exec_res;
    t_result                   run_res;
    t_result                   out_res;

    logic                      is_load;
    logic                      is_clear;
    logic                      is_tick;
    logic                      table_full;
    logic [SLOT_W-1:0]         load_slot;
    logic                      zero_burst;
    logic                      do_load;
    logic                      cand_eligible;
    logic                      cand_better;
    logic                      cand_take;
    logic                      best_fin;
    logic                      run_now;

    assign is_load    = (r_cmd == CMD_LOAD);
    assign is_clear   = (r_cmd == CMD_CLEAR);
    assign is_tick    = (r_cmd == CMD_TICK);
    assign table_full = (r_load_count == COUNT_W'(MAX_PROCS));
    assign load_slot  = r_load_count[SLOT_W-1:0];
    assign zero_burst = (r_burst_in == '0);
    assign do_load    = i_ctrl.exec && is_load && !table_full;
    assign run_now    = i_ctrl.update && r_best_found;
    assign best_fin   = (r_best_rem == BURST_W'(1));

    always_comb begin
        cand_eligible = !r_ent_done[r_scan_idx] &&
                        ({{(SIM_W-TIME_W){1'b0}}, r_ent_arr[r_scan_idx]} <= r_sim_time);
        if (!r_best_found) begin
            cand_better = 1'b1;
        end else if (r_ent_nice[r_scan_idx] != r_best_nice) begin
            cand_better = (r_ent_nice[r_scan_idx] < r_best_nice);
        end else if (r_ent_arr[r_scan_idx] != r_best_arr) begin
            cand_better = (r_ent_arr[r_scan_idx] < r_best_arr);
        end else begin
            cand_better = (r_ent_id[r_scan_idx] < r_best_id);
        end
        cand_take = i_ctrl.scan_step && cand_eligible && cand_better;
    end

    always_comb begin
        exec_res            = '0;
        exec_res.slot_time  = is_clear ? '0 : r_sim_time;
        exec_res.load_error = is_load && table_full;
        run_res             = r_res;
        run_res.busy_res    = 1'b1;
        run_res.running_id  = r_best_id;
        run_res.switched    = !r_last_valid || (r_last_slot != r_best_slot);
        run_res.first_run   = !r_ent_started[r_best_slot];
        run_res.finished    = best_fin;
        out_res             = r_res;
        out_res.all_done    = (r_done_count == r_load_count);
    end

    assign o_stat.is_tick   = is_tick;
    assign o_stat.empty     = (r_load_count == '0);
    assign o_stat.scan_last = ((COUNT_W'(r_scan_idx) + COUNT_W'(1)) == r_load_count);
    assign o_stat.out_free  = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.capture) begin
            r_cmd      <= i_cmd;
            r_id_in    <= i_proc_id;
            r_arr_in   <= i_arrival;
            r_nice_in  <= i_nice;
            r_burst_in <= i_burst;
        end
        if (do_load) begin
            r_ent_id[load_slot]   <= r_id_in;
            r_ent_arr[load_slot]  <= r_arr_in;
            r_ent_nice[load_slot] <= r_nice_in;
            r_ent_rem[load_slot]  <= r_burst_in;
        end else if (run_now) begin
            r_ent_rem[r_best_slot] <= r_best_rem - BURST_W'(1);
        end
        if (cand_take) begin
            r_best_slot <= r_scan_idx;
            r_best_nice <= r_ent_nice[r_scan_idx];
            r_best_arr  <= r_ent_arr[r_scan_idx];
            r_best_id   <= r_ent_id[r_scan_idx];
            r_best_rem  <= r_ent_rem[r_scan_idx];
        end
        if (i_ctrl.exec) begin
            r_res <= exec_res;
        end else if (run_now) begin
            r_res <= run_res;
        end
        if (i_ctrl.out_load) begin
            r_out <= out_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ent_done    <= '0;
            r_ent_started <= '0;
            r_sim_time    <= '0;
            r_load_count  <= '0;
            r_done_count  <= '0;
            r_last_valid  <= 1'b0;
            r_last_slot   <= '0;
            r_scan_idx    <= '0;
            r_best_found  <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_ctrl.exec && is_clear) begin
                r_ent_done    <= '0;
                r_ent_started <= '0;
                r_sim_time    <= '0;
                r_load_count  <= '0;
                r_done_count  <= '0;
                r_last_valid  <= 1'b0;
            end else if (do_load) begin
                r_ent_done[load_slot]    <= zero_burst;
                r_ent_started[load_slot] <= 1'b0;
                r_load_count             <= r_load_count + COUNT_W'(1);
                if (zero_burst) begin
                    r_done_count <= r_done_count + COUNT_W'(1);
                end
            end else if (i_ctrl.update) begin
                r_sim_time <= r_sim_time + SIM_W'(1);
                if (r_best_found) begin
                    r_ent_started[r_best_slot] <= 1'b1;
                    r_last_valid               <= 1'b1;
                    r_last_slot                <= r_best_slot;
                    if (best_fin) begin
                        r_ent_done[r_best_slot] <= 1'b1;
                        r_done_count            <= r_done_count + COUNT_W'(1);
                    end
                end
            end
            if (i_ctrl.exec) begin
                r_scan_idx   <= '0;
                r_best_found <= 1'b0;
            end else if (i_ctrl.scan_step) begin
                r_scan_idx <= r_scan_idx + SLOT_W'(1);
                if (cand_take) begin
                    r_best_found <= 1'b1;
                end
            end
            if (i_ctrl.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_result    = r_out;

`ifndef NO_ASSERTIONS
    a_done_le_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done_count <= r_load_count)
        else $error("done count exceeds load count");

    a_load_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_load_count <= COUNT_W'(MAX_PROCS))
        else $error("load count exceeds table size");

    a_scan_in_table: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.scan_step |-> (COUNT_W'(r_scan_idx) < r_load_count))
        else $error("scan beyond loaded entries");

    a_run_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out.finished || r_out.first_run || r_out.switched))
            |-> r_out.busy_res)
        else $error("run flags set on an idle result");
`endif

endmodule
`default_nettype wire
